@@ rtl/core/rws_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rws_pkg
// Shared types and fixed field widths for the roulette wheel selector.
// ---------------------------------------------------------------------------
package rws_pkg;

  // fixed field widths of the transaction payloads
  localparam int IDX_W = 10;
  localparam int RND_W = 31;
  localparam int CFG_W = 11;

  // entry count after reset
  localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

  // input transaction kinds
  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

endpackage

@@ rtl/core/rws_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rws_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/roulette_wheel_select_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// roulette_wheel_select_top
// Fitness-proportional selection over a store of share weights.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------
//  in_     | input     | in_valid/in_ready   | action, entry_index, share, random_value
//  out_    | output    | out_valid/out_ready | selected_index, zero_total
//  cfg_    | input     | cfg_we              | cfg_wdata = entry_count
//
//  A load is written to the share store on accept. A draw runs a summing RAM
//  pass, a restoring divider and a walking RAM pass, which share one
//  adder/subtracter; a zero total skips the divider and the walk. in_ready is
//  high only while the sequencer is idle.
//  A finished result waits in the output register; the sequencer stalls at its
//  end only while that register is still full. Reset is synchronous, no RAM clear.
//
module roulette_wheel_select_top #(
  parameter int MAX_ENTRIES = 1024,
  parameter int SHARE_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input transactions
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rws_pkg::action_t            in_action,
  input  logic [rws_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [SHARE_BITS-1:0]       in_share,
  input  logic [rws_pkg::RND_W-1:0]   in_random_value,
  // result transactions
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rws_pkg::IDX_W-1:0]   out_selected_index,
  output logic                        out_zero_total,
  // configuration
  input  logic                        cfg_we,
  input  logic [rws_pkg::CFG_W-1:0]   cfg_wdata
);

  import rws_pkg::*;

  localparam int ADDR_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int TOTAL_W = SHARE_BITS + CNT_W;
  localparam int ALU_W   = TOTAL_W + 1;
  localparam int DCNT_W  = $clog2(RND_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_WALK,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    entry_count_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0]   data_idx_r, data_idx_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [TOTAL_W-1:0]  rem_r, rem_nxt;
  logic [TOTAL_W-1:0]  sum_r, sum_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [DCNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [ADDR_W-1:0]   res_idx_r, res_idx_nxt;
  logic                res_zero_r, res_zero_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_zero_r, out_zero_nxt;

  logic                in_accept;
  logic                idx_in_range;
  logic [CNT_W-1:0]    count_sat;
  logic                issue;
  logic                last_entry;
  logic                hit;
  logic [ALU_W-1:0]    rem_shift;
  logic [ALU_W-1:0]    alu_a, alu_b;
  logic                alu_sub;
  logic [ALU_W:0]      alu_res;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SHARE_BITS-1:0] ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // share store
  assign idx_in_range = 32'(in_entry_index) < 32'(MAX_ENTRIES);
  assign ram_we       = in_accept && (in_action == ACT_LOAD) && idx_in_range;
  assign ram_waddr    = ADDR_W'(in_entry_index);
  assign ram_raddr    = ptr_r[ADDR_W-1:0];

  rws_ram #(
    .WIDTH (SHARE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_share_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_share),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry count saturated to the store depth
  assign count_sat = (32'(entry_count_r) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                             : CNT_W'(entry_count_r);

  // read issue and walk end conditions
  assign issue      = ptr_r < count_r;
  assign last_entry = (CNT_W'(data_idx_r) + CNT_W'(1)) >= count_r;
  assign rem_shift  = {rem_r, rnd_r[RND_W-1]};

  // shared adder / subtracter
  always_comb begin
    alu_a   = ALU_W'(total_r);
    alu_b   = ALU_W'(ram_rdata);
    alu_sub = 1'b0;
    case (state_r)
      S_DIV: begin
        alu_a   = rem_shift;
        alu_b   = ALU_W'(total_r);
        alu_sub = 1'b1;
      end
      S_WALK: begin
        alu_a = ALU_W'(sum_r);
      end
      default: begin
        alu_a = ALU_W'(total_r);
      end
    endcase
  end

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (ALU_W + 1)'(alu_sub);
  assign hit     = alu_res[TOTAL_W-1:0] > rem_r;

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rd_pend_nxt   = rd_pend_r;
    data_idx_nxt  = data_idx_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    sum_nxt       = sum_r;
    rnd_nxt       = rnd_r;
    div_cnt_nxt   = div_cnt_r;
    res_idx_nxt   = res_idx_r;
    res_zero_nxt  = res_zero_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_zero_nxt  = out_zero_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == ACT_DRAW)) begin
          count_nxt   = count_sat;
          ptr_nxt     = '0;
          rd_pend_nxt = 1'b0;
          total_nxt   = '0;
          rnd_nxt     = in_random_value;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        ptr_nxt      = ptr_r + CNT_W'(issue);
        rd_pend_nxt  = issue;
        data_idx_nxt = ptr_r[ADDR_W-1:0];
        if (rd_pend_r) begin
          total_nxt = alu_res[TOTAL_W-1:0];
        end
        if (!issue && !rd_pend_r) begin
          if (total_r == '0) begin
            res_idx_nxt  = '0;
            res_zero_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            rem_nxt     = '0;
            div_cnt_nxt = DCNT_W'(RND_W - 1);
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = alu_res[ALU_W] ? alu_res[TOTAL_W-1:0] : rem_shift[TOTAL_W-1:0];
        rnd_nxt = {rnd_r[RND_W-2:0], 1'b0};
        if (div_cnt_r == '0) begin
          ptr_nxt     = '0;
          rd_pend_nxt = 1'b0;
          sum_nxt     = '0;
          state_nxt   = S_WALK;
        end else begin
          div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        end
      end
      S_WALK: begin
        ptr_nxt      = ptr_r + CNT_W'(issue);
        rd_pend_nxt  = issue;
        data_idx_nxt = ptr_r[ADDR_W-1:0];
        if (rd_pend_r) begin
          sum_nxt = alu_res[TOTAL_W-1:0];
          if (hit || last_entry) begin
            res_idx_nxt  = data_idx_r;
            res_zero_nxt = 1'b0;
            state_nxt    = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(res_idx_r);
          out_zero_nxt  = res_zero_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, datapath and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= ENTRY_COUNT_RESET;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
    end
    count_r    <= count_nxt;
    ptr_r      <= ptr_nxt;
    data_idx_r <= data_idx_nxt;
    total_r    <= total_nxt;
    rem_r      <= rem_nxt;
    sum_r      <= sum_nxt;
    rnd_r      <= rnd_nxt;
    div_cnt_r  <= div_cnt_nxt;
    res_idx_r  <= res_idx_nxt;
    res_zero_r <= res_zero_nxt;
    out_idx_r  <= out_idx_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;
  assign out_zero_total     = out_zero_r;

  // a zero total always reports index zero
  a_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_total |-> out_selected_index == '0)
    else $error("zero total with nonzero index");

  // the remainder stays below the total during division and walk
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) || (state_r == S_WALK) |-> rem_r < total_r)
    else $error("remainder not below total");

  // the read pointer never passes the entry count
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) || (state_r == S_WALK) |-> ptr_r <= count_r)
    else $error("read pointer beyond entry count");

  // a draw closes the input side on the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_DRAW) |=> !in_ready)
    else $error("input still open after draw accept");

  // the walk only runs with a nonzero total
  a_walk_total: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> total_r != '0)
    else $error("walk with zero total");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives load and draw transactions into roulette_wheel_select_top, keeps a
// copy of the share store, predicts each selected index and checks every
// result in order, across several entry count settings and random stalls.
// ---------------------------------------------------------------------------
module testbench;
  import rws_pkg::*;

  typedef struct {
    action_t           action;
    logic [IDX_W-1:0]  entry_index;
    logic [15:0]       share;
    logic [RND_W-1:0]  random_value;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             zero_total;
  } selection_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  action_t          in_action = ACT_LOAD;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic [15:0]      in_share = '0;
  logic [RND_W-1:0] in_random_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [IDX_W-1:0] out_selected_index;
  logic             out_zero_total;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // predictor state, follows accepted transactions
  logic [15:0]      share_mirror [1024];
  logic [CFG_W-1:0] count_setting = ENTRY_COUNT_RESET;

  // stimulus side bookkeeping
  bit               gen_loaded [1024];
  request_t         pending_requests [$];
  selection_t       expected_selections [$];
  bit               no_gaps = 1'b0;
  int               mismatches = 0;

  roulette_wheel_select_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_share           (in_share),
    .in_random_value    (in_random_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_selected_index (out_selected_index),
    .out_zero_total     (out_zero_total),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // fitness-proportional pick over the mirrored share store
  function automatic selection_t predict_selection(logic [RND_W-1:0] rnd);
    int unsigned     used;
    longint unsigned total;
    longint unsigned reduced;
    longint unsigned running;
    selection_t      sel;
    used = (count_setting > 11'd1024) ? 1024 : count_setting;
    total = 0;
    for (int i = 0; i < used; i++) total += share_mirror[i];
    sel.index = '0;
    sel.zero_total = 1'b1;
    if (total != 0) begin
      reduced = rnd % total;
      running = 0;
      sel.zero_total = 1'b0;
      for (int i = 0; i < used; i++) begin
        running += share_mirror[i];
        sel.index = IDX_W'(i);
        if (running > reduced) break;
      end
    end
    return sel;
  endfunction

  // driver: offers queued transactions, predicts on accept
  always @(posedge clk) begin : driver
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD) share_mirror[in_entry_index] = in_share;
        else expected_selections.push_back(predict_selection(in_random_value));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && (no_gaps || $urandom_range(99) >= 15)) begin
          req = pending_requests.pop_front();
          in_valid        <= 1'b1;
          in_action       <= req.action;
          in_entry_index  <= req.entry_index;
          in_share        <= req.share;
          in_random_value <= req.random_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results in order, with one long hold-off
  always @(posedge clk) begin : monitor
    selection_t want;
    int         results_seen;
    int         hold_left;
    bit         hold_done;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_selections.size() == 0) begin
          $display("%0t: unexpected result, actual index %0d zero_total %0b",
                   $time, out_selected_index, out_zero_total);
          mismatches++;
        end else begin
          want = expected_selections.pop_front();
          if (out_selected_index !== want.index) begin
            $display("%0t: selected_index expected %0d actual %0d",
                     $time, want.index, out_selected_index);
            mismatches++;
          end
          if (out_zero_total !== want.zero_total) begin
            $display("%0t: zero_total expected %0b actual %0b",
                     $time, want.zero_total, out_zero_total);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 30 && !hold_done && pending_requests.size() >= 10) begin
        // hold off while the sender still has plenty queued
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(99) >= 15);
      end
    end
  end

  // share values biased toward zero and full scale
  function automatic logic [15:0] pick_share();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return 16'd0;
    if (pick < 40) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  task automatic push_load(int unsigned idx, logic [15:0] share);
    request_t req;
    req.action       = ACT_LOAD;
    req.entry_index  = IDX_W'(idx);
    req.share        = share;
    req.random_value = RND_W'($urandom);
    gen_loaded[idx]  = 1'b1;
    pending_requests.push_back(req);
  endtask

  task automatic push_draw(logic [RND_W-1:0] rnd);
    request_t req;
    req.action       = ACT_DRAW;
    req.entry_index  = IDX_W'($urandom);
    req.share        = 16'($urandom);
    req.random_value = rnd;
    pending_requests.push_back(req);
  endtask

  // sender pause until the block has drained every result
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_selections.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_entry_count(logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    count_setting = value;
  endtask

  // stimulus
  initial begin
    int unsigned count;
    int unsigned span;
    int unsigned items;
    for (int i = 0; i < 1024; i++) begin
      share_mirror[i] = '0;
      gen_loaded[i]   = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // four entries with zero and full scale shares
    set_entry_count(11'd4);
    push_load(0, 16'd0);
    push_load(1, 16'hFFFF);
    push_load(2, 16'd0);
    push_load(3, 16'd1);
    push_draw(31'd0);
    push_draw(31'd65535);
    push_draw(31'd65536);
    push_draw(31'h7FFF_FFFF);
    wait_idle();

    // single entry: zero total, also with a share loaded beyond the count, then a normal pick
    set_entry_count(11'd1);
    push_load(0, 16'd0);
    push_draw(31'h7FFF_FFFF);
    push_load(1023, 16'hFFFF);
    push_draw(31'd0);
    push_load(0, 16'd5);
    push_draw(31'd7);
    wait_idle();

    // no entries in use
    set_entry_count(11'd0);
    push_draw(31'h5555_5555);
    wait_idle();

    // random phases over several counts
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: count = 3;
        1: count = 1;
        2: count = 16;
        3: count = 40;
        4: count = 5;
        5: count = 64;
        6: count = 8;
        7: count = 48;
        8: count = 2;
        default: count = $urandom_range(2, 40);
      endcase
      no_gaps = (p == 4);
      set_entry_count(CFG_W'(count));
      span = (count > 1024) ? 1024 : count;
      items = 20;
      // every entry in use holds a share before the first draw
      for (int i = 0; i < span; i++) if (!gen_loaded[i]) push_load(i, pick_share());
      if (p == 6) begin
        // all shares zero, then only the last one set so the walk runs to the end
        for (int i = 0; i < span; i++) push_load(i, 16'd0);
        push_draw(RND_W'($urandom));
        push_load(span - 1, 16'hFFFF);
        push_draw(RND_W'($urandom));
      end
      for (int n = 0; n < items; n++) begin
        if ($urandom_range(99) < 45) begin
          if ($urandom_range(99) < 60) push_load($urandom_range(span - 1), pick_share());
          else push_load($urandom_range(1023), pick_share());
        end else if ($urandom_range(99) < 80) begin
          push_draw(RND_W'($urandom));
        end else begin
          push_draw(RND_W'($urandom_range(200)));
        end
      end
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS roulette_wheel_select_top");
    end else begin
      $display("FAIL roulette_wheel_select_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL roulette_wheel_select_top");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rws_pkg.sv
rtl/core/rws_ram.sv
rtl/core/roulette_wheel_select_top.sv
test/testbench.sv
